/* rtl/paillier_pkg.sv */
// ----------------------------------------------------------------------------
// paillier_pkg
// Widths, command and status codes and register indexes shared by the Paillier block.
// ----------------------------------------------------------------------------
package paillier_pkg;

    localparam int DATA_W  = 64;
    localparam int KEY_W   = 32;
    localparam int IDX_W   = 3;
    localparam int COUNT_W = $clog2(DATA_W);

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    localparam logic [IDX_W-1:0] REG_MODULUS   = 3'd0;
    localparam logic [IDX_W-1:0] REG_MODULUS_SQ = 3'd1;
    localparam logic [IDX_W-1:0] REG_GENERATOR = 3'd2;
    localparam logic [IDX_W-1:0] REG_LAMBDA    = 3'd3;
    localparam logic [IDX_W-1:0] REG_MU        = 3'd4;

endpackage

/* rtl/paillier_encrypt_decrypt.sv */
// ----------------------------------------------------------------------------
// paillier_encrypt_decrypt
// Paillier encrypt / decrypt with a 32-bit modulus, bit-serial modular arithmetic.
//
//   channel   signals                                    handshake
//   command   start, command, plaintext, blinding,       start & !busy
//             ciphertext
//   result    value, status                              done, one cycle
//   config    wr_en, wr_index, wr_data                   wr_en
//
// One shared bit-serial modular multiplier (a doubling phase and an adding
// phase per multiplier bit) and one bit-serial restoring divider do all the
// work. Each exponentiation takes up to 2 products per exponent bit. One item
// at a time; busy stays high until done pulses. The result is shown for one
// cycle and cannot be stalled. Reset loads modulus 2, modulus_squared 4 and
// clears the other key words.
// ----------------------------------------------------------------------------
module paillier_encrypt_decrypt
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              command,
    input  logic [paillier_pkg::DATA_W-1:0]   plaintext,
    input  logic [paillier_pkg::DATA_W-1:0]   blinding,
    input  logic [paillier_pkg::DATA_W-1:0]   ciphertext,
    output logic                              done,
    output logic [paillier_pkg::DATA_W-1:0]   value,
    output logic                              status,
    input  logic                              wr_en,
    input  logic [paillier_pkg::IDX_W-1:0]    wr_index,
    input  logic [paillier_pkg::DATA_W-1:0]   wr_data
);
    import paillier_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_EXP, S_NEXT} state_t;
    typedef enum logic [3:0] {
        ST_M, ST_G, ST_X1, ST_R, ST_X2, ST_OUT, ST_C, ST_U, ST_L, ST_Q
    } step_t;
    typedef enum logic [1:0] {T_ACC, T_SQ, T_FIN} target_t;

    state_t              state_reg;
    step_t               step_reg;
    target_t             tgt_reg;

    logic [KEY_W-1:0]    modulus_reg;
    logic [DATA_W-1:0]   modsq_reg;
    logic [DATA_W-1:0]   gen_reg;
    logic [DATA_W-1:0]   lambda_reg;
    logic [KEY_W-1:0]    mu_reg;

    logic [DATA_W-1:0]   blind_reg;
    logic [DATA_W-1:0]   num_reg;
    logic [DATA_W-1:0]   rem_reg;
    logic [DATA_W-1:0]   quot_reg;
    logic [DATA_W-1:0]   dm_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0]   ma_reg;
    logic [DATA_W-1:0]   mb_reg;
    logic [DATA_W-1:0]   mm_reg;
    logic [DATA_W-1:0]   macc_reg;
    logic                mph_reg;
    logic [DATA_W-1:0]   sq_reg;
    logic [DATA_W-1:0]   pacc_reg;
    logic [DATA_W-1:0]   e_reg;
    logic [DATA_W-1:0]   c1_reg;
    logic                done_reg;
    logic [DATA_W-1:0]   value_reg;
    logic                status_reg;

    logic [DATA_W:0]     rem2;
    logic                rge;
    logic [DATA_W-1:0]   rnew;
    logic [DATA_W-1:0]   addy;
    logic [DATA_W:0]     msum;
    logic                sge;
    logic [DATA_W-1:0]   snew;
    logic [DATA_W-1:0]   one_n2;
    logic [DATA_W-1:0]   n_ext;

    // divider step: shift in one numerator bit, subtract when it fits
    assign rem2 = {rem_reg, num_reg[DATA_W-1]};
    assign rge  = rem2 >= {1'b0, dm_reg};
    assign rnew = rge ? DATA_W'(rem2 - {1'b0, dm_reg}) : rem2[DATA_W-1:0];

    // multiplier step: phase 0 doubles, phase 1 adds the multiplicand when the top multiplier bit is set
    assign addy = mph_reg ? ma_reg : macc_reg;
    assign msum = {1'b0, macc_reg} + {1'b0, addy};
    assign sge  = msum >= {1'b0, mm_reg};
    assign snew = sge ? DATA_W'(msum - {1'b0, mm_reg}) : msum[DATA_W-1:0];

    assign one_n2 = (modsq_reg == DATA_W'(1)) ? '0 : DATA_W'(1);
    assign n_ext  = DATA_W'(modulus_reg);

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign value  = value_reg;
    assign status = status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= KEY_W'(2);
            modsq_reg   <= DATA_W'(4);
            gen_reg     <= '0;
            lambda_reg  <= '0;
            mu_reg      <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_MODULUS:    modulus_reg <= wr_data[KEY_W-1:0];
                REG_MODULUS_SQ: modsq_reg   <= wr_data;
                REG_GENERATOR:  gen_reg     <= wr_data;
                REG_LAMBDA:     lambda_reg  <= wr_data;
                REG_MU:         mu_reg      <= wr_data[KEY_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= ST_M;
            tgt_reg   <= T_FIN;
            done_reg  <= 1'b0;
            mph_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        blind_reg <= blinding;
                        rem_reg   <= '0;
                        quot_reg  <= '0;
                        cnt_reg   <= '0;
                        if (modulus_reg == '0 || modsq_reg == '0)
                        begin
                            value_reg  <= '0;
                            status_reg <= STATUS_ERROR;
                            done_reg   <= 1'b1;
                        end
                        else if (command == CMD_ENCRYPT)
                        begin
                            num_reg   <= plaintext;
                            dm_reg    <= n_ext;
                            step_reg  <= ST_M;
                            state_reg <= S_DIV;
                        end
                        else
                        begin
                            num_reg   <= ciphertext;
                            dm_reg    <= modsq_reg;
                            step_reg  <= ST_C;
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    rem_reg  <= rnew;
                    quot_reg <= {quot_reg[DATA_W-2:0], rge};
                    num_reg  <= {num_reg[DATA_W-2:0], 1'b0};
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == COUNT_W'(DATA_W-1))
                        state_reg <= S_NEXT;
                end
                S_MUL:
                begin
                    mph_reg <= ~mph_reg;
                    if (!mph_reg || mb_reg[DATA_W-1])
                        macc_reg <= snew;
                    if (mph_reg)
                    begin
                        mb_reg  <= {mb_reg[DATA_W-2:0], 1'b0};
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == COUNT_W'(DATA_W-1))
                        begin
                            unique case (tgt_reg)
                                T_ACC:
                                begin
                                    pacc_reg  <= (mb_reg[DATA_W-1]) ? snew : macc_reg;
                                    e_reg[0]  <= 1'b0;
                                    state_reg <= S_EXP;
                                end
                                T_SQ:
                                begin
                                    sq_reg    <= (mb_reg[DATA_W-1]) ? snew : macc_reg;
                                    e_reg     <= {1'b0, e_reg[DATA_W-1:1]};
                                    state_reg <= S_EXP;
                                end
                                default:
                                begin
                                    value_reg  <= (mb_reg[DATA_W-1]) ? snew : macc_reg;
                                    status_reg <= STATUS_OK;
                                    done_reg   <= 1'b1;
                                    state_reg  <= S_IDLE;
                                end
                            endcase
                        end
                    end
                end
                S_EXP:
                begin
                    // multiply in the current square where the exponent bit is set, else square it
                    cnt_reg  <= '0;
                    mph_reg  <= 1'b0;
                    macc_reg <= '0;
                    mm_reg   <= modsq_reg;
                    if (e_reg == '0)
                        state_reg <= S_NEXT;
                    else if (e_reg[0])
                    begin
                        ma_reg    <= pacc_reg;
                        mb_reg    <= sq_reg;
                        tgt_reg   <= T_ACC;
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        ma_reg    <= sq_reg;
                        mb_reg    <= sq_reg;
                        tgt_reg   <= T_SQ;
                        state_reg <= S_MUL;
                    end
                end
                S_NEXT:
                begin
                    cnt_reg  <= '0;
                    mph_reg  <= 1'b0;
                    macc_reg <= '0;
                    unique case (step_reg)
                        ST_M:
                        begin
                            e_reg     <= rem_reg;
                            num_reg   <= gen_reg;
                            dm_reg    <= modsq_reg;
                            rem_reg   <= '0;
                            step_reg  <= ST_G;
                            state_reg <= S_DIV;
                        end
                        ST_G:
                        begin
                            sq_reg    <= rem_reg;
                            pacc_reg  <= one_n2;
                            step_reg  <= ST_X1;
                            state_reg <= S_EXP;
                        end
                        ST_X1:
                        begin
                            c1_reg    <= pacc_reg;
                            num_reg   <= blind_reg;
                            dm_reg    <= modsq_reg;
                            rem_reg   <= '0;
                            step_reg  <= ST_R;
                            state_reg <= S_DIV;
                        end
                        ST_R:
                        begin
                            sq_reg    <= rem_reg;
                            pacc_reg  <= one_n2;
                            e_reg     <= n_ext;
                            step_reg  <= ST_X2;
                            state_reg <= S_EXP;
                        end
                        ST_X2:
                        begin
                            ma_reg    <= c1_reg;
                            mb_reg    <= pacc_reg;
                            mm_reg    <= modsq_reg;
                            tgt_reg   <= T_FIN;
                            step_reg  <= ST_OUT;
                            state_reg <= S_MUL;
                        end
                        ST_C:
                        begin
                            sq_reg    <= rem_reg;
                            pacc_reg  <= one_n2;
                            e_reg     <= lambda_reg;
                            step_reg  <= ST_U;
                            state_reg <= S_EXP;
                        end
                        ST_U:
                        begin
                            // u - 1 wraps at zero
                            num_reg   <= pacc_reg - DATA_W'(1);
                            dm_reg    <= n_ext;
                            rem_reg   <= '0;
                            quot_reg  <= '0;
                            step_reg  <= ST_L;
                            state_reg <= S_DIV;
                        end
                        ST_L:
                        begin
                            if (rem_reg != '0)
                            begin
                                value_reg  <= '0;
                                status_reg <= STATUS_ERROR;
                                done_reg   <= 1'b1;
                                state_reg  <= S_IDLE;
                            end
                            else
                            begin
                                num_reg   <= quot_reg;
                                dm_reg    <= n_ext;
                                rem_reg   <= '0;
                                step_reg  <= ST_Q;
                                state_reg <= S_DIV;
                            end
                        end
                        ST_Q:
                        begin
                            ma_reg    <= rem_reg;
                            mb_reg    <= DATA_W'(mu_reg);
                            mm_reg    <= n_ext;
                            tgt_reg   <= T_FIN;
                            step_reg  <= ST_OUT;
                            state_reg <= S_MUL;
                        end
                        default:
                            state_reg <= S_IDLE;
                    endcase
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && modulus_reg != '0 && modsq_reg != '0) |=> busy)
        else $error("accepted word did not start work");

    a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL && mph_reg) |=> !mph_reg)
        else $error("multiplier phase did not alternate");

endmodule
